@@ rtl/core/srhe_pkg.sv @@
// shared types and constants for the spin rate and heading estimator
`timescale 1ns / 1ps
`default_nettype none

package srhe_pkg;

    // field widths
    localparam int ACCEL_W   = 16;
    localparam int TIME_W    = 32;
    localparam int RADIUS_W  = 16;
    localparam int RATE_W    = 20;
    localparam int HEADING_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_SENSOR   = 2'd2;

    // configuration reset values
    localparam logic [RADIUS_W-1:0] INNER_RADIUS_RST = 16'd500;
    localparam logic [RADIUS_W-1:0] OUTER_OFFSET_RST = 16'd0;

    // squared rate numerator: accel * 98000 * 4096
    localparam int SCALE_W = 17;
    localparam logic [SCALE_W-1:0] ACCEL_SCALE = 17'd98000;
    localparam int QSHIFT_W = 12;
    localparam int NUM_W    = 45;
    localparam int DIVISOR_W = RADIUS_W + 1;
    localparam int DIV_STEPS = NUM_W;

    // square root of a 40-bit value, two bits per step
    localparam int SQ_W       = 40;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int SREM_W     = RATE_W + 1;
    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    // step counter covers the longest iteration
    localparam int CNT_W = 6;

    // heading gain floor(2^101 / (1000 * floor(pi * 2^48)))
    localparam logic [127:0] GAIN_WIDE =
        (128'd1 << 101) / (128'd1000 * 128'h3243F6A8885A3);
    localparam int GAIN_W = 42;
    localparam int KL_W   = 21;
    localparam int KH_W   = GAIN_W - KL_W;
    localparam logic [GAIN_W-1:0] HEADING_GAIN = GAIN_WIDE[GAIN_W-1:0];
    localparam logic [KL_W-1:0] GAIN_LO = HEADING_GAIN[KL_W-1:0];
    localparam logic [KH_W-1:0] GAIN_HI = HEADING_GAIN[GAIN_W-1:KL_W];

    // rate times elapsed time, split in halves for the partial products
    localparam int PROD_W = RATE_W + TIME_W - 20;
    localparam int PL_W   = 26;
    localparam int PH_W   = 26;
    localparam int MUL_W  = 64;
    localparam int INC_LSB = 48;

    // multiplier operations
    typedef enum logic [2:0] {
        MUL_ACCEL,
        MUL_DELTA,
        MUL_LL,
        MUL_LH,
        MUL_HL,
        MUL_HH
    } mul_op_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_ACCEL,
        S_DIV_INIT,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_RATE,
        S_MUL_DELTA,
        S_PROD,
        S_PP_LL,
        S_PP_LH,
        S_PP_HL,
        S_PP_HH,
        S_ACC_LAST,
        S_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    sensor_outer;
        logic    mul_en;
        mul_op_t mul_op;
        logic    acc_clr;
        logic    acc_en;
        logic    div_init;
        logic    div_step;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    rate_load;
        logic    rate_avg;
        logic    prod_load;
        logic    out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic two_sensor;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/srhe_datapath.sv @@
// datapath: config registers, shared multiplier, divider, square root, heading
`timescale 1ns / 1ps
`default_nettype none

module srhe_datapath (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_we,
    input  wire  [srhe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [srhe_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire  [srhe_pkg::ACCEL_W-1:0]          s_accel_inner,
    input  wire  [srhe_pkg::ACCEL_W-1:0]          s_accel_outer,
    input  wire  [srhe_pkg::TIME_W-1:0]           s_time_ms,
    input  srhe_pkg::cmd_t                        cmd,
    output srhe_pkg::status_t                     status,
    output logic [srhe_pkg::RATE_W-1:0]           m_spin_rate,
    output logic [srhe_pkg::HEADING_W-1:0]        m_heading
);

    // configuration
    logic [srhe_pkg::RADIUS_W-1:0] inner_radius_reg;
    logic [srhe_pkg::RADIUS_W-1:0] outer_offset_reg;
    logic                          two_sensor_reg;

    // captured request
    logic [srhe_pkg::ACCEL_W-1:0]  accel_inner_reg;
    logic [srhe_pkg::ACCEL_W-1:0]  accel_outer_reg;
    logic [srhe_pkg::TIME_W-1:0]   time_reg;

    // running state
    logic [srhe_pkg::TIME_W-1:0]    prev_time_reg;
    logic [srhe_pkg::HEADING_W-1:0] heading_reg;
    logic [srhe_pkg::HEADING_W-1:0] heading_next;

    // multiplier and accumulator
    logic [srhe_pkg::MUL_W-1:0] mul_reg;
    srhe_pkg::mul_op_t          mul_op_reg;
    logic [31:0]                mul_a;
    logic [31:0]                mul_b;
    logic [srhe_pkg::MUL_W-1:0] mul_prod;
    logic [srhe_pkg::MUL_W-1:0] acc_reg;
    logic [srhe_pkg::MUL_W-1:0] acc_addend;
    logic [srhe_pkg::PROD_W+20-1:0] prod_reg;
    logic [srhe_pkg::TIME_W-1:0] delta;

    // divider
    logic [srhe_pkg::NUM_W-1:0]     num_reg;
    logic [srhe_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [srhe_pkg::DIVISOR_W-1:0] drem_reg;
    logic [srhe_pkg::DIVISOR_W:0]   dtrial;
    logic                           dge;
    logic [srhe_pkg::DIVISOR_W-1:0] radius_sel;
    logic [srhe_pkg::ACCEL_W-1:0]   accel_sel;

    // square root
    logic [srhe_pkg::SQ_W-1:0]     sq_reg;
    logic                          sat_reg;
    logic [srhe_pkg::SREM_W-1:0]   srem_reg;
    logic [srhe_pkg::RATE_W-1:0]   root_reg;
    logic [srhe_pkg::SREM_W+1:0]   sr2;
    logic [srhe_pkg::SREM_W+1:0]   strial;
    logic                          sge;
    logic [srhe_pkg::SREM_W+1:0]   sdiff;

    // rates
    logic [srhe_pkg::RATE_W-1:0] rate_reg;
    logic [srhe_pkg::RATE_W-1:0] sensor_rate;
    logic [srhe_pkg::RATE_W:0]   rate_sum;

    // output registers
    logic [srhe_pkg::RATE_W-1:0]    out_rate_reg;
    logic [srhe_pkg::HEADING_W-1:0] out_heading_reg;

    assign status.two_sensor = two_sensor_reg;
    assign m_spin_rate = out_rate_reg;
    assign m_heading   = out_heading_reg;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_radius_reg <= srhe_pkg::INNER_RADIUS_RST;
            outer_offset_reg <= srhe_pkg::OUTER_OFFSET_RST;
            two_sensor_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                srhe_pkg::CFG_INNER_RADIUS: inner_radius_reg <= cfg_data;
                srhe_pkg::CFG_OUTER_OFFSET: outer_offset_reg <= cfg_data;
                srhe_pkg::CFG_TWO_SENSOR:   two_sensor_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sensor selection
    assign accel_sel  = cmd.sensor_outer ? accel_outer_reg : accel_inner_reg;
    assign radius_sel = cmd.sensor_outer
                      ? ({1'b0, inner_radius_reg} + {1'b0, outer_offset_reg})
                      : {1'b0, inner_radius_reg};
    assign delta = time_reg - prev_time_reg;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            srhe_pkg::MUL_ACCEL: begin
                mul_a = {16'b0, accel_sel};
                mul_b = {15'b0, srhe_pkg::ACCEL_SCALE};
            end
            srhe_pkg::MUL_DELTA: begin
                mul_a = {12'b0, rate_reg};
                mul_b = delta;
            end
            srhe_pkg::MUL_LL: begin
                mul_a = {6'b0, prod_reg[srhe_pkg::PL_W-1:0]};
                mul_b = {11'b0, srhe_pkg::GAIN_LO};
            end
            srhe_pkg::MUL_LH: begin
                mul_a = {6'b0, prod_reg[srhe_pkg::PL_W-1:0]};
                mul_b = {11'b0, srhe_pkg::GAIN_HI};
            end
            srhe_pkg::MUL_HL: begin
                mul_a = {6'b0, prod_reg[srhe_pkg::PL_W+srhe_pkg::PH_W-1:srhe_pkg::PL_W]};
                mul_b = {11'b0, srhe_pkg::GAIN_LO};
            end
            srhe_pkg::MUL_HH: begin
                mul_a = {6'b0, prod_reg[srhe_pkg::PL_W+srhe_pkg::PH_W-1:srhe_pkg::PL_W]};
                mul_b = {11'b0, srhe_pkg::GAIN_HI};
            end
            default: ;
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // partial product alignment, kept modulo 2^64
    always_comb begin
        case (mul_op_reg)
            srhe_pkg::MUL_LH: acc_addend = mul_reg << srhe_pkg::KL_W;
            srhe_pkg::MUL_HL: acc_addend = mul_reg << srhe_pkg::PL_W;
            srhe_pkg::MUL_HH: acc_addend = mul_reg << (srhe_pkg::PL_W + srhe_pkg::KL_W);
            default:          acc_addend = mul_reg;
        endcase
    end

    // restoring division step
    assign dtrial = {drem_reg, num_reg[srhe_pkg::NUM_W-1]};
    assign dge    = (dtrial >= {1'b0, divisor_reg});

    // square root step, two radicand bits per step
    assign sr2    = {srem_reg, sq_reg[srhe_pkg::SQ_W-1 -: 2]};
    assign strial = {1'b0, root_reg, 2'b01};
    assign sge    = (sr2 >= strial);
    assign sdiff  = sr2 - strial;

    assign sensor_rate = sat_reg ? srhe_pkg::RATE_MAX : root_reg;
    assign rate_sum    = {1'b0, rate_reg} + {1'b0, sensor_rate};
    assign heading_next = heading_reg + acc_reg[srhe_pkg::INC_LSB +: srhe_pkg::HEADING_W];

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            accel_inner_reg <= s_accel_inner;
            accel_outer_reg <= s_accel_outer;
            time_reg        <= s_time_ms;
        end
    end

    // multiplier register and accumulator
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            mul_reg    <= mul_prod;
            mul_op_reg <= cmd.mul_op;
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + acc_addend;
        end
        if (cmd.prod_load) begin
            prod_reg <= mul_reg[srhe_pkg::PL_W+srhe_pkg::PH_W-1:0];
        end
    end

    // divider registers
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            num_reg     <= {mul_reg[srhe_pkg::NUM_W-srhe_pkg::QSHIFT_W-1:0],
                            {srhe_pkg::QSHIFT_W{1'b0}}};
            drem_reg    <= '0;
            divisor_reg <= radius_sel;
        end else if (cmd.div_step) begin
            num_reg  <= {num_reg[srhe_pkg::NUM_W-2:0], dge};
            drem_reg <= dge ? srhe_pkg::DIVISOR_W'(dtrial - {1'b0, divisor_reg})
                            : dtrial[srhe_pkg::DIVISOR_W-1:0];
        end
    end

    // square root registers
    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            sq_reg   <= num_reg[srhe_pkg::SQ_W-1:0];
            sat_reg  <= |num_reg[srhe_pkg::NUM_W-1:srhe_pkg::SQ_W];
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            sq_reg   <= {sq_reg[srhe_pkg::SQ_W-3:0], 2'b00};
            srem_reg <= sge ? sdiff[srhe_pkg::SREM_W-1:0] : sr2[srhe_pkg::SREM_W-1:0];
            root_reg <= {root_reg[srhe_pkg::RATE_W-2:0], sge};
        end
    end

    // spin rate: single sensor or average of both
    always_ff @(posedge aclk) begin
        if (cmd.rate_load) begin
            rate_reg <= sensor_rate;
        end else if (cmd.rate_avg) begin
            rate_reg <= rate_sum[srhe_pkg::RATE_W:1];
        end
    end

    // timestamp and heading state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
            heading_reg   <= '0;
        end else begin
            if (cmd.prod_load) begin
                prev_time_reg <= time_reg;
            end
            if (cmd.out_load) begin
                heading_reg <= heading_next;
            end
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_rate_reg    <= rate_reg;
            out_heading_reg <= heading_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/srhe_ctrl.sv @@
// controller: sequences multiply, divide, square root and heading steps
`timescale 1ns / 1ps
`default_nettype none

module srhe_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    input  srhe_pkg::status_t    status,
    output srhe_pkg::cmd_t       cmd
);

    srhe_pkg::state_t state_reg;
    srhe_pkg::state_t state_next;
    logic [srhe_pkg::CNT_W-1:0] count_reg;
    logic [srhe_pkg::CNT_W-1:0] count_next;
    logic sensor_reg;
    logic sensor_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srhe_pkg::S_IDLE;
            count_reg   <= '0;
            sensor_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sensor_reg  <= sensor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        sensor_next = sensor_reg;
        unique case (state_reg)
            srhe_pkg::S_IDLE: begin
                sensor_next = 1'b0;
                if (s_valid) begin
                    state_next = srhe_pkg::S_MUL_ACCEL;
                end
            end
            srhe_pkg::S_MUL_ACCEL: state_next = srhe_pkg::S_DIV_INIT;
            srhe_pkg::S_DIV_INIT: begin
                count_next = '0;
                state_next = srhe_pkg::S_DIV;
            end
            srhe_pkg::S_DIV: begin
                count_next = count_reg + 1'b1;
                if (count_reg == srhe_pkg::CNT_W'(srhe_pkg::DIV_STEPS - 1)) begin
                    state_next = srhe_pkg::S_SQRT_INIT;
                end
            end
            srhe_pkg::S_SQRT_INIT: begin
                count_next = '0;
                state_next = srhe_pkg::S_SQRT;
            end
            srhe_pkg::S_SQRT: begin
                count_next = count_reg + 1'b1;
                if (count_reg == srhe_pkg::CNT_W'(srhe_pkg::SQRT_STEPS - 1)) begin
                    state_next = srhe_pkg::S_RATE;
                end
            end
            srhe_pkg::S_RATE: begin
                if (!sensor_reg && status.two_sensor) begin
                    sensor_next = 1'b1;
                    state_next  = srhe_pkg::S_MUL_ACCEL;
                end else begin
                    state_next = srhe_pkg::S_MUL_DELTA;
                end
            end
            srhe_pkg::S_MUL_DELTA: state_next = srhe_pkg::S_PROD;
            srhe_pkg::S_PROD:      state_next = srhe_pkg::S_PP_LL;
            srhe_pkg::S_PP_LL:     state_next = srhe_pkg::S_PP_LH;
            srhe_pkg::S_PP_LH:     state_next = srhe_pkg::S_PP_HL;
            srhe_pkg::S_PP_HL:     state_next = srhe_pkg::S_PP_HH;
            srhe_pkg::S_PP_HH:     state_next = srhe_pkg::S_ACC_LAST;
            srhe_pkg::S_ACC_LAST:  state_next = srhe_pkg::S_FINISH;
            srhe_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = srhe_pkg::S_IDLE;
                end
            end
            default: state_next = srhe_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        cmd              = '0;
        cmd.mul_op       = srhe_pkg::MUL_ACCEL;
        cmd.sensor_outer = sensor_reg;
        s_ready          = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        unique case (state_reg)
            srhe_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            srhe_pkg::S_MUL_ACCEL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = srhe_pkg::MUL_ACCEL;
            end
            srhe_pkg::S_DIV_INIT:  cmd.div_init  = 1'b1;
            srhe_pkg::S_DIV:       cmd.div_step  = 1'b1;
            srhe_pkg::S_SQRT_INIT: cmd.sqrt_init = 1'b1;
            srhe_pkg::S_SQRT:      cmd.sqrt_step = 1'b1;
            srhe_pkg::S_RATE: begin
                cmd.rate_load = !sensor_reg;
                cmd.rate_avg  = sensor_reg;
            end
            srhe_pkg::S_MUL_DELTA: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = srhe_pkg::MUL_DELTA;
            end
            srhe_pkg::S_PROD: begin
                cmd.prod_load = 1'b1;
                cmd.acc_clr   = 1'b1;
            end
            srhe_pkg::S_PP_LL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = srhe_pkg::MUL_LL;
            end
            srhe_pkg::S_PP_LH: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = srhe_pkg::MUL_LH;
                cmd.acc_en = 1'b1;
            end
            srhe_pkg::S_PP_HL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = srhe_pkg::MUL_HL;
                cmd.acc_en = 1'b1;
            end
            srhe_pkg::S_PP_HH: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = srhe_pkg::MUL_HH;
                cmd.acc_en = 1'b1;
            end
            srhe_pkg::S_ACC_LAST: cmd.acc_en = 1'b1;
            srhe_pkg::S_FINISH: begin
                cmd.out_load = out_free;
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/spin_rate_heading_estimator.sv @@
// top level of the spin rate and heading estimator
//
// each request on s_ carries one or two centripetal acceleration readings
// (unsigned Q8.8 g) and a millisecond timestamp; the result on m_ gives the
// spin rate (Q10.10 rad/s, saturating) and the accumulated 16-bit heading.
// both channels are valid/ready; the config port writes inner_radius (0),
// outer_offset (1) and two_sensor_mode (2) on cfg_we. the user must write
// the config only while idle; the block does not enforce this. one request
// is processed at a time. per sensor a 45-step restoring divider and a
// 20-step square root run on shared registers; the heading is then formed
// on one shared 32x32 multiplier. the result sits in an output register:
// the next request is accepted while it waits, and a stalled receiver only
// holds the block in its last state. reset clears the config to its
// defaults, the stored timestamp and heading to zero, and drops any pending
// result.
`timescale 1ns / 1ps
`default_nettype none

module spin_rate_heading_estimator (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire  [srhe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [srhe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [srhe_pkg::ACCEL_W-1:0]       s_accel_inner,
    input  wire  [srhe_pkg::ACCEL_W-1:0]       s_accel_outer,
    input  wire  [srhe_pkg::TIME_W-1:0]        s_time_ms,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [srhe_pkg::RATE_W-1:0]        m_spin_rate,
    output logic [srhe_pkg::HEADING_W-1:0]     m_heading
);

    srhe_pkg::cmd_t    cmd;
    srhe_pkg::status_t status;

    // sequencer
    srhe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and state
    srhe_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_accel_inner (s_accel_inner),
        .s_accel_outer (s_accel_outer),
        .s_time_ms     (s_time_ms),
        .cmd           (cmd),
        .status        (status),
        .m_spin_rate   (m_spin_rate),
        .m_heading     (m_heading)
    );

endmodule

`default_nettype wire

@@ tb/sv/spin_rate_heading_estimator_tb.sv @@
// self-checking testbench for the spin rate and heading estimator
`timescale 1ns / 1ps

module spin_rate_heading_estimator_tb;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;
    localparam int MAX_GAP      = 17;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;
    localparam int TAIL_CYCLES  = 160;
    localparam int IDLE_LIMIT   = 5000;

    localparam logic [srhe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [srhe_pkg::RATE_W-1:0] OMEGA_SAT = '1;
    // Q10.10 rad/s times milliseconds to binary angle, scaled by 2^48
    localparam logic [127:0] TURN_GAIN =
        (128'd1 << 101) / (128'd1000 * 128'h3243F6A8885A3);

    typedef struct packed {
        logic [srhe_pkg::RATE_W-1:0]    omega;
        logic [srhe_pkg::HEADING_W-1:0] angle;
    } reading_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_RATE, CHK_BOTH} row_check_t;

    typedef struct {
        row_kind_t                           kind;
        logic [srhe_pkg::CFG_IDX_W-1:0]      reg_idx;
        logic [srhe_pkg::CFG_DATA_W-1:0]     reg_val;
        logic [srhe_pkg::ACCEL_W-1:0]        a_in;
        logic [srhe_pkg::ACCEL_W-1:0]        a_out;
        logic [srhe_pkg::TIME_W-1:0]         stamp;
        row_check_t                          check;
        logic [srhe_pkg::RATE_W-1:0]         rate_val;
        logic [srhe_pkg::HEADING_W-1:0]      head_val;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [srhe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [srhe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [srhe_pkg::ACCEL_W-1:0] s_accel_inner = '0;
    logic [srhe_pkg::ACCEL_W-1:0] s_accel_outer = '0;
    logic [srhe_pkg::TIME_W-1:0] s_time_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [srhe_pkg::RATE_W-1:0] m_spin_rate;
    logic [srhe_pkg::HEADING_W-1:0] m_heading;

    // predictor copy of configuration and state
    logic [15:0] radius_reg = 16'd500;
    logic [15:0] offset_reg = '0;
    logic        dual_reg = 1'b0;
    logic [31:0] held_stamp = '0;
    logic [15:0] held_heading = '0;

    reading_t due[$];
    row_t     plan[$];
    int       errors = 0;
    int       quiet_cycles = 0;
    bit       send_calm = 1'b0;
    bit       recv_calm = 1'b0;
    bit       hold_req = 1'b0;

    spin_rate_heading_estimator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_accel_inner (s_accel_inner),
        .s_accel_outer (s_accel_outer),
        .s_time_ms     (s_time_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_spin_rate   (m_spin_rate),
        .m_heading     (m_heading)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // floor of the square root, one result bit per pass
    function automatic logic [19:0] root_floor(input logic [39:0] v);
        logic [19:0] root;
        logic [19:0] trial;
        root = '0;
        for (int b = 19; b >= 0; b--) begin
            trial = root | (20'd1 << b);
            if (40'(trial) * 40'(trial) <= v) root = trial;
        end
        return root;
    endfunction

    // rate of one sensor in Q10.10, zero radius or overflow saturates
    function automatic logic [19:0] sensor_omega(input logic [15:0] accel,
                                                 input logic [16:0] radius);
        logic [63:0] sq;
        if (radius == '0) return OMEGA_SAT;
        sq = (64'(accel) * 64'd98000 * 64'd4096) / 64'(radius);
        if (sq >= (64'd1 << 40)) return OMEGA_SAT;
        return root_floor(sq[39:0]);
    endfunction

    // expected rate and heading for one request, advances the stored state
    function automatic reading_t track_spin(input logic [15:0] a_in, a_out,
                                            input logic [31:0] stamp);
        reading_t     res;
        logic [19:0]  omega;
        logic [20:0]  pair_sum;
        logic [31:0]  span;
        logic [127:0] turn;
        omega = sensor_omega(a_in, {1'b0, radius_reg});
        if (dual_reg) begin
            pair_sum = 21'(omega) +
                       21'(sensor_omega(a_out, 17'(radius_reg) + 17'(offset_reg)));
            omega = pair_sum[20:1];
        end
        span = stamp - held_stamp;
        held_stamp = stamp;
        turn = 128'(omega) * 128'(span) * TURN_GAIN;
        held_heading = held_heading + turn[63:48];
        res.omega = omega;
        res.angle = held_heading;
        return res;
    endfunction

    function automatic logic [15:0] pick_accel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 16'($urandom_range(0, 255));
            // around the saturation edge at a radius of one
            3: return 16'($urandom_range(2600, 2900));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_write(input logic [1:0] idx, input logic [15:0] val);
        row_t r;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        r.a_in = '0;
        r.a_out = '0;
        r.stamp = '0;
        r.check = CHK_MODEL;
        r.rate_val = '0;
        r.head_val = '0;
        plan.push_back(r);
    endtask

    task automatic add_sample(input logic [15:0] a_in, a_out, input logic [31:0] stamp,
                              input row_check_t check, input logic [19:0] rate_val,
                              input logic [15:0] head_val);
        row_t r;
        r.kind = ROW_SAMPLE;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.a_in = a_in;
        r.a_out = a_out;
        r.stamp = stamp;
        r.check = check;
        r.rate_val = rate_val;
        r.head_val = head_val;
        plan.push_back(r);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            srhe_pkg::CFG_INNER_RADIUS: radius_reg = val;
            srhe_pkg::CFG_OUTER_OFFSET: offset_reg = val;
            srhe_pkg::CFG_TWO_SENSOR:   dual_reg = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // stop offering and wait until every expected result is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic offer_sample(input logic [15:0] a_in, a_out,
                                input logic [31:0] stamp, input reading_t want);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_accel_inner <= a_in;
        s_accel_outer <= a_out;
        s_time_ms <= stamp;
        do @(posedge aclk); while (!(s_valid && s_ready));
        due.push_back(want);
    endtask

    // result side: random stalls, one long hold on request
    initial begin : result_sink
        int stall;
        forever begin
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin : check_results
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due.size() == 0) begin
                $display("%0t: result with none expected: expected none, actual rate %0d heading %0d",
                         $time, m_spin_rate, m_heading);
                errors++;
            end else begin
                want = due.pop_front();
                if (m_spin_rate !== want.omega) begin
                    $display("%0t: spin_rate expected %0d actual %0d",
                             $time, want.omega, m_spin_rate);
                    errors++;
                end
                if (m_heading !== want.angle) begin
                    $display("%0t: heading expected %0d actual %0d",
                             $time, want.angle, m_heading);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles where no request moves
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        reading_t    want;
        logic [15:0] a_in;
        logic [15:0] a_out;
        logic [31:0] stamp_now;
        logic [15:0] radius_pick;
        logic [15:0] offset_pick;
        logic        dual_pick;

        // directed table: reset state, extremes, zero radius, saturation,
        // timestamp wrap and going backwards, ignored register index
        add_sample(16'd0, 16'd0, 32'd0, CHK_BOTH, 20'd0, 16'd0);
        add_sample(16'd0, 16'd0, 32'hFFFF_FFFF, CHK_BOTH, 20'd0, 16'd0);
        add_sample(16'hFFFF, 16'hFFFF, 32'd0, CHK_MODEL, '0, '0);
        add_sample(16'h0100, 16'd0, 32'd1000, CHK_MODEL, '0, '0);
        add_sample(16'h0100, 16'd0, 32'd500, CHK_MODEL, '0, '0);
        add_write(srhe_pkg::CFG_INNER_RADIUS, 16'd0);
        add_sample(16'd0, 16'd0, 32'd2000, CHK_RATE, OMEGA_SAT, '0);
        add_write(srhe_pkg::CFG_INNER_RADIUS, 16'd1);
        add_sample(16'hFFFF, 16'd0, 32'd2001, CHK_RATE, OMEGA_SAT, '0);
        add_sample(16'd1, 16'd0, 32'd2002, CHK_MODEL, '0, '0);
        add_sample(16'd2739, 16'd0, 32'd2010, CHK_MODEL, '0, '0);
        add_sample(16'd2740, 16'd0, 32'd2020, CHK_RATE, OMEGA_SAT, '0);
        add_write(srhe_pkg::CFG_INNER_RADIUS, 16'hFFFF);
        add_write(srhe_pkg::CFG_OUTER_OFFSET, 16'hFFFF);
        add_write(srhe_pkg::CFG_TWO_SENSOR, 16'd1);
        add_sample(16'hFFFF, 16'hFFFF, 32'd3000, CHK_MODEL, '0, '0);
        add_sample(16'd0, 16'd0, 32'd3001, CHK_RATE, 20'd0, '0);
        add_write(srhe_pkg::CFG_INNER_RADIUS, 16'd0);
        add_write(srhe_pkg::CFG_OUTER_OFFSET, 16'd0);
        add_sample(16'h1234, 16'h5678, 32'd4000, CHK_RATE, OMEGA_SAT, '0);
        add_write(srhe_pkg::CFG_OUTER_OFFSET, 16'd1);
        add_sample(16'd0, 16'd0, 32'd4001, CHK_RATE, 20'd524287, '0);
        add_write(CFG_SPARE, 16'hFFFF);
        add_write(srhe_pkg::CFG_TWO_SENSOR, 16'hFFFE);
        add_sample(16'h1234, 16'hFFFF, 32'd5000, CHK_RATE, OMEGA_SAT, '0);
        add_write(srhe_pkg::CFG_INNER_RADIUS, 16'd500);
        add_write(srhe_pkg::CFG_OUTER_OFFSET, 16'd0);
        add_sample(16'hFFFF, 16'd0, 32'h8000_1387, CHK_MODEL, '0, '0);

        // synchronous reset
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_for_results();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                want = track_spin(plan[i].a_in, plan[i].a_out, plan[i].stamp);
                if (plan[i].check != CHK_MODEL) want.omega = plan[i].rate_val;
                if (plan[i].check == CHK_BOTH) want.angle = plan[i].head_val;
                offer_sample(plan[i].a_in, plan[i].a_out, plan[i].stamp, want);
            end
        end

        // random phases, each with its own register setting
        stamp_now = 32'h8000_1387;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    radius_pick = 16'd1;
                    offset_pick = 16'd0;
                    dual_pick = 1'b0;
                end
                1: begin
                    radius_pick = 16'hFFFF;
                    offset_pick = 16'hFFFF;
                    dual_pick = 1'b1;
                end
                2: begin
                    radius_pick = 16'd0;
                    offset_pick = 16'($urandom);
                    dual_pick = 1'b1;
                end
                default: begin
                    radius_pick = $urandom_range(0, 1) ? 16'($urandom_range(1, 2000))
                                                       : 16'($urandom_range(1, 65535));
                    offset_pick = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
                    dual_pick = 1'($urandom_range(0, 1));
                end
            endcase
            wait_for_results();
            write_reg(CFG_SPARE, 16'($urandom));
            write_reg(srhe_pkg::CFG_INNER_RADIUS, radius_pick);
            write_reg(srhe_pkg::CFG_OUTER_OFFSET, offset_pick);
            write_reg(srhe_pkg::CFG_TWO_SENSOR, (16'($urandom) & 16'hFFFE) | 16'(dual_pick));
            recv_calm = (p % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_calm = (p % 3 == 1) || (n >= 30 && n < 50);
                if (p == 3 && n == 40) hold_req = 1'b1;
                if (p == 5 && n == 60) wait_for_results();
                a_in = pick_accel();
                a_out = pick_accel();
                // mostly steady sampling, some wraps, repeats and jumps back
                case ($urandom_range(0, 19))
                    0: stamp_now = $urandom;
                    1: stamp_now = stamp_now - $urandom_range(1, 5000);
                    2: ;
                    default: stamp_now = stamp_now + $urandom_range(1, 3000);
                endcase
                want = track_spin(a_in, a_out, stamp_now);
                offer_sample(a_in, a_out, stamp_now, want);
            end
        end

        // drain and let the block run out
        s_valid <= 1'b0;
        while (due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
